### rtl/contact_point_likelihood_top_assert.svh
// Assertion macros for the contact point likelihood checker.
// Needs a clock named i_clk and an active-low reset named i_rst_n in scope.
`ifndef CONTACT_POINT_LIKELIHOOD_TOP_ASSERT_SVH
`define CONTACT_POINT_LIKELIHOOD_TOP_ASSERT_SVH

// Same-cycle implication, off while in reset.
`define CLPL_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("clpl assertion failed");

// Next-cycle implication, active through reset.
`define CLPL_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) (ante) |=> (cons)) \
        else $error("clpl assertion failed");

`endif

### rtl/clpl_pkg.sv
// Shared constants, register indexes and stage-to-stage structs for the
// contact point likelihood pipeline. No dependencies.
package clpl_pkg;

    localparam int SQRT_STAGES = 32;
    localparam int DIV_BITS    = 18;
    localparam int EXP_TERMS   = 14;
    localparam int POW_STAGES  = 11;
    localparam int LATENCY     = 6 + SQRT_STAGES + 2 + DIV_BITS + 1
                                 + 3 * EXP_TERMS + 1 + POW_STAGES + 1;

    localparam logic [2:0] REG_MF_X = 3'd0;
    localparam logic [2:0] REG_MF_Y = 3'd1;
    localparam logic [2:0] REG_MF_Z = 3'd2;
    localparam logic [2:0] REG_MT_X = 3'd3;
    localparam logic [2:0] REG_MT_Y = 3'd4;
    localparam logic [2:0] REG_MT_Z = 3'd5;
    localparam logic [2:0] REG_AXIS = 3'd6;

    localparam logic [31:0] ONE_Q31    = 32'h8000_0000;
    localparam logic [15:0] K_LIK_ZERO = 16'd12;

    // exp(-1) in Q0.31 as the truncated series gives it
    function automatic logic [31:0] calc_e1();
        logic [31:0]        t;
        logic signed [35:0] s;
        t = ONE_Q31;
        s = 36'sh0_8000_0000;
        t = t / 32'd1;  s = s - $signed({4'b0, t});
        t = t / 32'd2;  s = s + $signed({4'b0, t});
        t = t / 32'd3;  s = s - $signed({4'b0, t});
        t = t / 32'd4;  s = s + $signed({4'b0, t});
        t = t / 32'd5;  s = s - $signed({4'b0, t});
        t = t / 32'd6;  s = s + $signed({4'b0, t});
        t = t / 32'd7;  s = s - $signed({4'b0, t});
        t = t / 32'd8;  s = s + $signed({4'b0, t});
        t = t / 32'd9;  s = s - $signed({4'b0, t});
        t = t / 32'd10; s = s + $signed({4'b0, t});
        t = t / 32'd11; s = s - $signed({4'b0, t});
        t = t / 32'd12; s = s + $signed({4'b0, t});
        t = t / 32'd13; s = s - $signed({4'b0, t});
        t = t / 32'd14; s = s + $signed({4'b0, t});
        if (s < 0) begin
            s = '0;
        end
        return s[31:0];
    endfunction

    localparam logic [31:0] E1_Q31 = calc_e1();

    typedef struct packed {
        logic signed [31:0] mf_x;
        logic signed [31:0] mf_y;
        logic signed [31:0] mf_z;
        logic signed [31:0] mt_x;
        logic signed [31:0] mt_y;
        logic signed [31:0] mt_z;
        logic [2:0]         axis;
    } t_cfg;

    typedef struct packed {
        logic               valid;
        logic [63:0]        fsq;
        logic [63:0]        tsq;
        logic [63:0]        msq;
        logic signed [49:0] dot;
        logic               zero;
    } t_front;

    typedef struct packed {
        logic               valid;
        logic signed [49:0] dot;
        logic               zero;
        logic [31:0]        fnorm;
        logic [31:0]        tnorm;
        logic [31:0]        mnorm;
    } t_align_in;

    typedef struct packed {
        logic               valid;
        logic [31:0]        fnorm;
        logic [31:0]        tnorm;
        logic signed [19:0] align;
        logic               zero;
    } t_cost_in;

    typedef struct packed {
        logic        valid;
        logic [15:0] lik;
        logic [31:0] cost;
        logic        zero;
    } t_result;

endpackage

### rtl/contact_point_likelihood_top.sv
// Contact point likelihood top level: scores one candidate contact point per
// transfer against the measured wrench held in configuration registers.
//
// Input channel: an item transfers at a rising edge with start high and busy
// low. busy is low whenever reset is released, so one item may transfer in
// every cycle; the pipeline never stalls.
// Result channel: o_strobe marks each result for exactly one cycle, with
// o_likelihood (Q0.16), o_cost_value (Q16.16) and o_zero_force_flag. The
// receiver cannot hold results off, so none is buffered.
// Pipeline: the front stages, the 32-stage square root, the 18-stage
// alignment divide, the 42-stage exp series (3 stages per term) and the
// exp(-1) power stages lie between an input transfer and its o_strobe.
// Throughput: one item a cycle.
// Configuration: a write transfers when i_cfg_valid and o_cfg_ready are both
// high; index 0..5 measured force and torque, 6 axis enable, 7 ignored.
// Write only with no item in flight.
// Reset: synchronous, active low; clears the pipeline valids and loads the
// registers with zero wrench and all axes enabled. No clearing pass follows.
module contact_point_likelihood_top import clpl_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic signed [31:0] i_point_x,
    input  logic signed [31:0] i_point_y,
    input  logic signed [31:0] i_point_z,
    input  logic signed [15:0] i_normal_x,
    input  logic signed [15:0] i_normal_y,
    input  logic signed [15:0] i_normal_z,
    input  logic signed [31:0] i_cand_force_x,
    input  logic signed [31:0] i_cand_force_y,
    input  logic signed [31:0] i_cand_force_z,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [2:0]         i_cfg_index,
    input  logic [31:0]        i_cfg_data,
    output logic               o_strobe,
    output logic [15:0]        o_likelihood,
    output logic [31:0]        o_cost_value,
    output logic               o_zero_force_flag
);

    typedef struct packed {
        logic               valid;
        logic signed [49:0] dot;
        logic               zero;
    } t_dly;

    t_cfg      r_cfg;
    t_dly      r_dl [SQRT_STAGES];
    t_front    n_front;
    t_align_in n_align_in;
    t_cost_in  n_cost_in;
    t_result   n_res;
    logic      n_accept;
    logic [31:0] n_fnorm, n_tnorm, n_mnorm;
    logic signed [31:0] n_p [3];
    logic signed [15:0] n_n [3];
    logic signed [31:0] n_f [3];

    // hold off both channels while in reset
    assign busy        = !i_rst_n;
    assign o_cfg_ready = i_rst_n;
    assign n_accept    = start && !busy;

    // register file: drop writes beyond the axis enable
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '{mf_x: '0, mf_y: '0, mf_z: '0, mt_x: '0, mt_y: '0, mt_z: '0,
                       axis: 3'b111};
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                REG_MF_X: r_cfg.mf_x <= i_cfg_data;
                REG_MF_Y: r_cfg.mf_y <= i_cfg_data;
                REG_MF_Z: r_cfg.mf_z <= i_cfg_data;
                REG_MT_X: r_cfg.mt_x <= i_cfg_data;
                REG_MT_Y: r_cfg.mt_y <= i_cfg_data;
                REG_MT_Z: r_cfg.mt_z <= i_cfg_data;
                REG_AXIS: r_cfg.axis <= i_cfg_data[2:0];
                default: ;
            endcase
        end
    end

    assign n_p[0] = i_point_x;
    assign n_p[1] = i_point_y;
    assign n_p[2] = i_point_z;
    assign n_n[0] = i_normal_x;
    assign n_n[1] = i_normal_y;
    assign n_n[2] = i_normal_z;
    assign n_f[0] = i_cand_force_x;
    assign n_f[1] = i_cand_force_y;
    assign n_f[2] = i_cand_force_z;

    clpl_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_valid (n_accept),
        .i_p     (n_p),
        .i_n     (n_n),
        .i_f     (n_f),
        .o_front (n_front)
    );

    // three norms run side by side in lockstep
    clpl_sqrt u_sqrt_f (.i_clk(i_clk), .i_x(n_front.fsq), .o_root(n_fnorm));
    clpl_sqrt u_sqrt_t (.i_clk(i_clk), .i_x(n_front.tsq), .o_root(n_tnorm));
    clpl_sqrt u_sqrt_m (.i_clk(i_clk), .i_x(n_front.msq), .o_root(n_mnorm));

    // advance valid, dot product and zero flag alongside the roots
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < SQRT_STAGES; i++) begin
                r_dl[i].valid <= 1'b0;
            end
        end else begin
            r_dl[0] <= '{valid: n_front.valid, dot: n_front.dot, zero: n_front.zero};
            for (int i = 1; i < SQRT_STAGES; i++) begin
                r_dl[i] <= r_dl[i-1];
            end
        end
    end

    assign n_align_in = '{valid: r_dl[SQRT_STAGES-1].valid, dot: r_dl[SQRT_STAGES-1].dot,
                          zero: r_dl[SQRT_STAGES-1].zero, fnorm: n_fnorm,
                          tnorm: n_tnorm, mnorm: n_mnorm};

    clpl_align u_align (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (n_align_in),
        .o_out   (n_cost_in)
    );

    clpl_exp u_exp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (n_cost_in),
        .o_res   (n_res)
    );

    // the last exp stage is the output register
    assign o_strobe          = n_res.valid;
    assign o_likelihood      = n_res.lik;
    assign o_cost_value      = n_res.cost;
    assign o_zero_force_flag = n_res.zero;

endmodule

### rtl/clpl_front.sv
// Front stages: torque cross product, masked residuals, clamped magnitudes,
// squares, sums of squares, dot product and zero flag. Depends on clpl_pkg.
module clpl_front import clpl_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_cfg               i_cfg,
    input  logic               i_valid,
    input  logic signed [31:0] i_p [3],
    input  logic signed [15:0] i_n [3],
    input  logic signed [31:0] i_f [3],
    output t_front             o_front
);

    function automatic logic [31:0] mag_clamp(input logic signed [49:0] v);
        logic [49:0] m;
        m = v[49] ? 50'(-v) : 50'(v);
        return (m > 50'h0_8000_0000) ? ONE_Q31 : m[31:0];
    endfunction

    logic signed [31:0] mf [3];
    logic signed [31:0] mt [3];

    assign mf[0] = i_cfg.mf_x;
    assign mf[1] = i_cfg.mf_y;
    assign mf[2] = i_cfg.mf_z;
    assign mt[0] = i_cfg.mt_x;
    assign mt[1] = i_cfg.mt_y;
    assign mt[2] = i_cfg.mt_z;

    logic               r0_valid, r1_valid, r2_valid, r3_valid, r4_valid, r5_valid;
    logic signed [31:0] r0_p [3];
    logic signed [15:0] r0_n [3];
    logic signed [31:0] r0_f [3];
    logic signed [63:0] r1_cp [6];
    logic signed [47:0] r1_dot [3];
    logic signed [31:0] r1_f [3];
    logic signed [32:0] r2_rf [3];
    logic signed [49:0] r2_rt [3];
    logic signed [49:0] r2_d;
    logic [31:0]        r3_fm [3];
    logic [31:0]        r3_tm [3];
    logic [31:0]        r3_mm [3];
    logic signed [49:0] r3_d;
    logic [63:0]        r4_fs [3];
    logic [63:0]        r4_ts [3];
    logic [63:0]        r4_ms [3];
    logic signed [49:0] r4_d;
    logic [63:0]        r5_fsq, r5_tsq, r5_msq;
    logic signed [49:0] r5_d;
    logic               r5_zero;

    logic signed [48:0] n_t [3];
    logic signed [32:0] n_rf [3];
    logic signed [49:0] n_rt [3];
    logic signed [49:0] n_d;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n_t[i]  = {r1_cp[2*i][63], r1_cp[2*i][63:16]}
                      - {r1_cp[2*i+1][63], r1_cp[2*i+1][63:16]};
            n_rf[i] = {mf[i][31], mf[i]}
                      - (i_cfg.axis[i] ? {r1_f[i][31], r1_f[i]} : 33'd0);
            n_rt[i] = {{18{mt[i][31]}}, mt[i]}
                      - (i_cfg.axis[i] ? {n_t[i][48], n_t[i]} : 50'd0);
        end
        n_d = {{2{r1_dot[0][47]}}, r1_dot[0]} + {{2{r1_dot[1][47]}}, r1_dot[1]}
              + {{2{r1_dot[2][47]}}, r1_dot[2]};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r0_valid <= 1'b0;
            r1_valid <= 1'b0;
            r2_valid <= 1'b0;
            r3_valid <= 1'b0;
            r4_valid <= 1'b0;
            r5_valid <= 1'b0;
        end else begin
            r0_valid <= i_valid;
            r1_valid <= r0_valid;
            r2_valid <= r1_valid;
            r3_valid <= r2_valid;
            r4_valid <= r3_valid;
            r5_valid <= r4_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < 3; i++) begin
            r0_p[i]   <= i_p[i];
            r0_n[i]   <= i_n[i];
            r0_f[i]   <= i_f[i];
            r1_f[i]   <= r0_f[i];
            r1_dot[i] <= mf[i] * r0_n[i];
            r2_rf[i]  <= n_rf[i];
            r2_rt[i]  <= n_rt[i];
            r3_fm[i]  <= mag_clamp(50'(r2_rf[i]));
            r3_tm[i]  <= mag_clamp(r2_rt[i]);
            r3_mm[i]  <= mag_clamp(50'(mf[i]));
            r4_fs[i]  <= r3_fm[i] * r3_fm[i];
            r4_ts[i]  <= r3_tm[i] * r3_tm[i];
            r4_ms[i]  <= r3_mm[i] * r3_mm[i];
        end
        r1_cp[0] <= r0_p[1] * r0_f[2];
        r1_cp[1] <= r0_p[2] * r0_f[1];
        r1_cp[2] <= r0_p[2] * r0_f[0];
        r1_cp[3] <= r0_p[0] * r0_f[2];
        r1_cp[4] <= r0_p[0] * r0_f[1];
        r1_cp[5] <= r0_p[1] * r0_f[0];
        r2_d     <= n_d;
        r3_d     <= r2_d;
        r4_d     <= r3_d;
        r5_fsq   <= r4_fs[0] + r4_fs[1] + r4_fs[2];
        r5_tsq   <= r4_ts[0] + r4_ts[1] + r4_ts[2];
        r5_msq   <= r4_ms[0] + r4_ms[1] + r4_ms[2];
        r5_d     <= r4_d;
        r5_zero  <= (mf[0] == 32'sd0) && (mf[1] == 32'sd0) && (mf[2] == 32'sd0);
    end

    assign o_front.valid = r5_valid;
    assign o_front.fsq   = r5_fsq;
    assign o_front.tsq   = r5_tsq;
    assign o_front.msq   = r5_msq;
    assign o_front.dot   = r5_d;
    assign o_front.zero  = r5_zero;

endmodule

### rtl/clpl_sqrt.sv
// Pipelined floor square root of a 64-bit value, two radicand bits per stage.
// Depends on clpl_pkg.
module clpl_sqrt import clpl_pkg::*; (
    input  logic        i_clk,
    input  logic [63:0] i_x,
    output logic [31:0] o_root
);

    logic [63:0] r_x    [SQRT_STAGES-1];
    logic [33:0] r_rem  [SQRT_STAGES-1];
    logic [31:0] r_root [SQRT_STAGES];

    for (genvar g = 0; g < SQRT_STAGES; g++) begin : g_st
        logic [63:0] n_x_in;
        logic [33:0] n_rem_in;
        logic [31:0] n_root_in;
        logic [35:0] n_rem_sh;
        logic [35:0] n_trial;
        logic        n_take;

        if (g == 0) begin : g_first
            assign n_x_in    = i_x;
            assign n_rem_in  = '0;
            assign n_root_in = '0;
        end else begin : g_rest
            assign n_x_in    = r_x[g-1];
            assign n_rem_in  = r_rem[g-1];
            assign n_root_in = r_root[g-1];
        end

        assign n_rem_sh = {n_rem_in, n_x_in[63:62]};
        assign n_trial  = {2'b00, n_root_in, 2'b01};
        assign n_take   = (n_rem_sh >= n_trial);

        always_ff @(posedge i_clk) begin
            r_root[g] <= {n_root_in[30:0], n_take};
        end

        if (g < SQRT_STAGES - 1) begin : g_carry
            always_ff @(posedge i_clk) begin
                r_x[g]   <= {n_x_in[61:0], 2'b00};
                r_rem[g] <= n_take ? 34'(n_rem_sh - n_trial) : n_rem_sh[33:0];
            end
        end
    end

    assign o_root = r_root[SQRT_STAGES-1];

endmodule

### rtl/clpl_align.sv
// Alignment term: restoring divide of twice the force-normal dot product by
// the measured force norm, one quotient bit per stage. Depends on clpl_pkg.
module clpl_align import clpl_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_align_in i_in,
    output t_cost_in  o_out
);

    typedef struct packed {
        logic        valid;
        logic        neg;
        logic        zero;
        logic [31:0] fnorm;
        logic [31:0] tnorm;
        logic [31:0] mnorm;
    } t_dside;

    localparam logic signed [19:0] ALIGN_HALF = 20'sd32768;

    t_dside      r_p_sd;
    logic [49:0] r_p_mag;
    t_dside      r_sd  [DIV_BITS];
    logic [49:0] r_rem [DIV_BITS];
    logic [DIV_BITS-1:0] r_q [DIV_BITS];
    t_cost_in    r_out;

    logic [50:0] n_num;

    assign n_num = {i_in.dot, 1'b0};

    // abs of the numerator
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_sd.valid <= 1'b0;
        end else begin
            r_p_sd <= '{valid: i_in.valid, neg: i_in.dot[49], zero: i_in.zero,
                        fnorm: i_in.fnorm, tnorm: i_in.tnorm, mnorm: i_in.mnorm};
        end
    end

    always_ff @(posedge i_clk) begin
        r_p_mag <= i_in.dot[49] ? 50'(-n_num) : n_num[49:0];
    end

    for (genvar g = 0; g < DIV_BITS; g++) begin : g_st
        localparam int Bit = DIV_BITS - 1 - g;
        t_dside              n_sd_in;
        logic [49:0]         n_rem_in;
        logic [DIV_BITS-1:0] n_q_in;
        logic [49:0]         n_den;
        logic                n_take;

        if (g == 0) begin : g_first
            assign n_sd_in  = r_p_sd;
            assign n_rem_in = r_p_mag;
            assign n_q_in   = '0;
        end else begin : g_rest
            assign n_sd_in  = r_sd[g-1];
            assign n_rem_in = r_rem[g-1];
            assign n_q_in   = r_q[g-1];
        end

        assign n_den  = 50'(n_sd_in.mnorm) << Bit;
        assign n_take = (n_rem_in >= n_den);

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_sd[g].valid <= 1'b0;
            end else begin
                r_sd[g] <= n_sd_in;
            end
        end

        always_ff @(posedge i_clk) begin
            r_rem[g] <= n_take ? (n_rem_in - n_den) : n_rem_in;
            r_q[g]   <= n_q_in | (DIV_BITS'(n_take) << Bit);
        end
    end

    t_dside              n_last;
    logic [DIV_BITS-1:0] n_qf;
    logic signed [19:0]  n_align;

    assign n_last = r_sd[DIV_BITS-1];
    assign n_qf   = r_q[DIV_BITS-1];

    // zero measured force: hold the term at one half
    always_comb begin
        if (n_last.zero) begin
            n_align = ALIGN_HALF;
        end else if (n_last.neg) begin
            n_align = ALIGN_HALF - $signed({2'b00, n_qf});
        end else begin
            n_align = ALIGN_HALF + $signed({2'b00, n_qf});
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out.valid <= 1'b0;
        end else begin
            r_out <= '{valid: n_last.valid, fnorm: n_last.fnorm, tnorm: n_last.tnorm,
                       align: n_align, zero: n_last.zero};
        end
    end

    assign o_out = r_out;

endmodule

### rtl/clpl_exp.sv
// Cost sum and exp(-cost): pipelined alternating series for the fraction,
// then one multiply by exp(-1) per integer unit. Depends on clpl_pkg.
module clpl_exp import clpl_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_cost_in i_in,
    output t_result  o_res
);

    typedef struct packed {
        logic        valid;
        logic [31:0] cost;
        logic        zero;
    } t_side;

    t_side              r_c_sd;
    t_side              rA_sd   [EXP_TERMS];
    logic [31:0]        rA_p    [EXP_TERMS];
    logic signed [33:0] rA_sum  [EXP_TERMS];
    t_side              rB_sd   [EXP_TERMS];
    logic [65:0]        rB_mul  [EXP_TERMS];
    logic [31:0]        rB_p    [EXP_TERMS];
    logic signed [33:0] rB_sum  [EXP_TERMS];
    t_side              rC_sd   [EXP_TERMS];
    logic [31:0]        rC_term [EXP_TERMS-1];
    logic signed [33:0] rC_sum  [EXP_TERMS];
    t_side              r_k_sd;
    logic [31:0]        r_k_acc;
    t_side              r_w_sd  [POW_STAGES];
    logic [31:0]        r_w_acc [POW_STAGES];
    t_result            r_res;

    // cost = |rF|/4 + 5|rT|/2 + align, clamped to the unsigned Q16.16 range
    logic [34:0]        n_t5;
    logic signed [35:0] n_sum;
    logic [31:0]        n_cost;

    assign n_t5  = {1'b0, i_in.tnorm, 2'b00} + {3'b000, i_in.tnorm};
    assign n_sum = $signed({6'b0, i_in.fnorm[31:2]}) + $signed({2'b0, n_t5[34:1]})
                   + 36'(i_in.align);

    always_comb begin
        if (n_sum[35]) begin
            n_cost = '0;
        end else if (n_sum[35:32] != 4'd0) begin
            n_cost = '1;
        end else begin
            n_cost = n_sum[31:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_sd.valid <= 1'b0;
        end else begin
            r_c_sd <= '{valid: i_in.valid, cost: n_cost, zero: i_in.zero};
        end
    end

    for (genvar g = 0; g < EXP_TERMS; g++) begin : g_term
        localparam int Div = g + 1;
        localparam logic [33:0] Recip = 34'((64'd1 << 33) / Div);
        t_side              n_sd_in;
        logic [31:0]        n_term_in;
        logic signed [33:0] n_sum_in;
        logic [47:0]        n_prod;
        logic [31:0]        n_q0;
        logic [35:0]        n_qn;
        logic [31:0]        n_r;
        logic [31:0]        n_q;

        if (g == 0) begin : g_first
            assign n_sd_in   = r_c_sd;
            assign n_term_in = ONE_Q31;
            assign n_sum_in  = 34'sh0_8000_0000;
        end else begin : g_rest
            assign n_sd_in   = rC_sd[g-1];
            assign n_term_in = rC_term[g-1];
            assign n_sum_in  = rC_sum[g-1];
        end

        assign n_prod = 48'(n_term_in) * 48'(n_sd_in.cost[15:0]);
        // reciprocal estimate is low by at most one; correct with the remainder
        assign n_q0   = rB_mul[g][64:33];
        assign n_qn   = 36'(n_q0) * 36'(Div);
        assign n_r    = rB_p[g] - n_qn[31:0];
        assign n_q    = (n_r >= 32'(Div)) ? (n_q0 + 32'd1) : n_q0;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                rA_sd[g].valid <= 1'b0;
                rB_sd[g].valid <= 1'b0;
                rC_sd[g].valid <= 1'b0;
            end else begin
                rA_sd[g] <= n_sd_in;
                rB_sd[g] <= rA_sd[g];
                rC_sd[g] <= rB_sd[g];
            end
        end

        always_ff @(posedge i_clk) begin
            rA_p[g]   <= n_prod[47:16];
            rA_sum[g] <= n_sum_in;
            rB_mul[g] <= 66'(rA_p[g]) * 66'(Recip);
            rB_p[g]   <= rA_p[g];
            rB_sum[g] <= rA_sum[g];
        end

        if ((Div % 2) == 1) begin : g_sub
            always_ff @(posedge i_clk) begin
                rC_sum[g] <= rB_sum[g] - $signed({2'b00, n_q});
            end
        end else begin : g_add
            always_ff @(posedge i_clk) begin
                rC_sum[g] <= rB_sum[g] + $signed({2'b00, n_q});
            end
        end

        if (g < EXP_TERMS - 1) begin : g_carry
            always_ff @(posedge i_clk) begin
                rC_term[g] <= n_q;
            end
        end
    end

    logic signed [33:0] n_ser;
    logic [31:0]        n_acc0;

    assign n_ser = rC_sum[EXP_TERMS-1];

    always_comb begin
        if (n_ser < 0) begin
            n_acc0 = '0;
        end else if (n_ser > 34'sh0_8000_0000) begin
            n_acc0 = ONE_Q31;
        end else begin
            n_acc0 = n_ser[31:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_k_sd.valid <= 1'b0;
        end else begin
            r_k_sd <= rC_sd[EXP_TERMS-1];
        end
    end

    always_ff @(posedge i_clk) begin
        r_k_acc <= n_acc0;
    end

    for (genvar g = 0; g < POW_STAGES; g++) begin : g_pow
        t_side       n_sd_in;
        logic [31:0] n_acc_in;
        logic [63:0] n_mul;
        logic        n_apply;

        if (g == 0) begin : g_first
            assign n_sd_in  = r_k_sd;
            assign n_acc_in = r_k_acc;
        end else begin : g_rest
            assign n_sd_in  = r_w_sd[g-1];
            assign n_acc_in = r_w_acc[g-1];
        end

        assign n_mul   = 64'(n_acc_in) * 64'(E1_Q31) + 64'h4000_0000;
        assign n_apply = (n_sd_in.cost[31:16] > 16'(g));

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_w_sd[g].valid <= 1'b0;
            end else begin
                r_w_sd[g] <= n_sd_in;
            end
        end

        always_ff @(posedge i_clk) begin
            r_w_acc[g] <= n_apply ? n_mul[62:31] : n_acc_in;
        end
    end

    t_side       n_fin;
    logic [32:0] n_rnd;
    logic [17:0] n_l;
    logic [15:0] n_lik;

    assign n_fin = r_w_sd[POW_STAGES-1];
    assign n_rnd = {1'b0, r_w_acc[POW_STAGES-1]} + 33'h4000;
    assign n_l   = n_rnd[32:15];

    always_comb begin
        if (n_fin.cost[31:16] >= K_LIK_ZERO) begin
            n_lik = '0;
        end else if (n_l > 18'd65535) begin
            n_lik = '1;
        end else begin
            n_lik = n_l[15:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_res.valid <= 1'b0;
        end else begin
            r_res <= '{valid: n_fin.valid, lik: n_lik, cost: n_fin.cost,
                       zero: n_fin.zero};
        end
    end

    assign o_res = r_res;

endmodule

### rtl/clpl_checker.sv
// Port-level checker for the contact point likelihood block, bound to the top.
// Depends on clpl_pkg and contact_point_likelihood_top_assert.svh.
`include "contact_point_likelihood_top_assert.svh"

module clpl_checker import clpl_pkg::*; (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        start,
    input logic        busy,
    input logic        o_strobe,
    input logic [15:0] o_likelihood,
    input logic [31:0] o_cost_value,
    input logic        o_zero_force_flag
);

    logic n_xfer_in;
    logic n_cost_high;
    logic n_cost_zero;
    logic n_half_ok;

    assign n_xfer_in   = start && !busy;
    assign n_cost_high = (o_cost_value[31:16] >= K_LIK_ZERO);
    assign n_cost_zero = (o_cost_value == 32'd0);
    assign n_half_ok   = (o_cost_value >= 32'd32768) && (o_likelihood < 16'd40000);

    `CLPL_ASSERT_IMP(a_strobe_has_input, o_strobe, $past(n_xfer_in, LATENCY))
    `CLPL_ASSERT_IMP(a_high_cost_zero, o_strobe && n_cost_high, o_likelihood == 16'd0)
    `CLPL_ASSERT_IMP(a_zero_cost_one, o_strobe && n_cost_zero, o_likelihood == 16'hFFFF)
    `CLPL_ASSERT_IMP(a_zero_force_half, o_strobe && o_zero_force_flag, n_half_ok)
    `CLPL_ASSERT_NXT(a_reset_clears, !i_rst_n, !o_strobe)

endmodule

bind contact_point_likelihood_top clpl_checker u_clpl_checker (.*);

### tb/sv/tb.sv
// Self-checking testbench for contact_point_likelihood_top: directed and random contact
// candidates are scored by an in-bench fixed-point predictor and compared per result.
// Depends on clpl_pkg and the contact_point_likelihood_top RTL.
module tb;
    import clpl_pkg::*;

    localparam logic [2:0] REG_UNUSED = 3'd7;   // index past the last register
    localparam int         IDLE_LIMIT = 4000;   // cycles with no transfer at all
    localparam int         REPORT_MAX = 10;

    typedef struct {
        logic signed [31:0] px, py, pz;
        logic signed [15:0] nx, ny, nz;
        logic signed [31:0] fx, fy, fz;
    } t_contact;

    typedef struct {
        logic [15:0] lik;
        logic [31:0] cost;
        logic        zero;
    } t_score;

    logic               i_clk;
    logic               i_rst_n;
    logic               start;
    logic               busy;
    logic signed [31:0] i_point_x, i_point_y, i_point_z;
    logic signed [15:0] i_normal_x, i_normal_y, i_normal_z;
    logic signed [31:0] i_cand_force_x, i_cand_force_y, i_cand_force_z;
    logic               i_cfg_valid;
    logic               o_cfg_ready;
    logic [2:0]         i_cfg_index;
    logic [31:0]        i_cfg_data;
    logic               o_strobe;
    logic [15:0]        o_likelihood;
    logic [31:0]        o_cost_value;
    logic               o_zero_force_flag;

    // Predictor copy of the measured wrench and axis mask
    logic signed [31:0] wrench_force [3];
    logic signed [31:0] wrench_torque [3];
    logic [2:0]         axis_mask;

    t_score pending_scores [$];
    int     mismatch_count;
    int     idle_cycles;

    contact_point_likelihood_top DUT (.*);

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    // ------------------------------------------------------------------
    // Fixed-point predictor
    // ------------------------------------------------------------------
    function automatic longint unsigned clamp_mag(longint v);
        longint unsigned m;
        m = (v < 0) ? longint'(-v) : longint'(v);
        return (m > 64'h8000_0000) ? 64'h8000_0000 : m;
    endfunction

    function automatic longint unsigned floor_sqrt(longint unsigned x);
        longint unsigned r, b;
        r = 0;
        b = 64'h1 << 62;
        while (b > x) b = b >> 2;
        while (b != 0) begin
            if (x >= r + b) begin
                x = x - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    function automatic longint unsigned vec_norm(longint a, longint b, longint c);
        longint unsigned ma, mb, mc;
        ma = clamp_mag(a);
        mb = clamp_mag(b);
        mc = clamp_mag(c);
        return floor_sqrt(ma * ma + mb * mb + mc * mc);
    endfunction

    // exp(-x/65536) in Q0.31 from the truncated alternating series
    function automatic longint unsigned exp_series(longint unsigned x);
        longint unsigned term;
        longint          acc;
        term = 64'h8000_0000;
        acc  = 64'sh8000_0000;
        for (int n = 1; n <= 14; n++) begin
            term = ((term * x) >> 16) / n;
            if (n % 2 == 1) acc = acc - longint'(term);
            else            acc = acc + longint'(term);
        end
        if (acc < 0) acc = 0;
        if (acc > 64'sh8000_0000) acc = 64'sh8000_0000;
        return longint'(acc);
    endfunction

    // Torque P x F, each product floored to Q16.16
    function automatic void cross_torque(input longint p[3], input longint f[3],
                                         output longint t[3]);
        t[0] = ((p[1] * f[2]) >>> 16) - ((p[2] * f[1]) >>> 16);
        t[1] = ((p[2] * f[0]) >>> 16) - ((p[0] * f[2]) >>> 16);
        t[2] = ((p[0] * f[1]) >>> 16) - ((p[1] * f[0]) >>> 16);
    endfunction

    function automatic t_score score_contact(t_contact c);
        longint          p[3], f[3], n[3], t[3], rf[3], rt[3];
        longint          dot, num, align, total;
        longint unsigned fnorm, tnorm, mnorm, q, acc, e1, lik;
        int              k;
        t_score          s;
        p = '{c.px, c.py, c.pz};
        f = '{c.fx, c.fy, c.fz};
        n = '{c.nx, c.ny, c.nz};
        cross_torque(p, f, t);
        dot = 0;
        for (int i = 0; i < 3; i++) begin
            rf[i] = longint'(wrench_force[i]) - (axis_mask[i] ? f[i] : 0);
            rt[i] = longint'(wrench_torque[i]) - (axis_mask[i] ? t[i] : 0);
            dot   = dot + longint'(wrench_force[i]) * n[i];
        end
        fnorm  = vec_norm(rf[0], rf[1], rf[2]);
        tnorm  = vec_norm(rt[0], rt[1], rt[2]);
        s.zero = (wrench_force[0] == 0 && wrench_force[1] == 0 && wrench_force[2] == 0);
        if (s.zero) begin
            align = 32768;
        end else begin
            mnorm = vec_norm(wrench_force[0], wrench_force[1], wrench_force[2]);
            num   = 2 * dot;
            q     = ((num < 0) ? longint'(-num) : longint'(num)) / mnorm;
            align = 32768 + ((num < 0) ? -longint'(q) : longint'(q));
        end
        total = longint'(fnorm >> 2) + longint'((tnorm * 5) >> 1) + align;
        if (total < 0) total = 0;
        if (total > 64'sh0_FFFF_FFFF) total = 64'sh0_FFFF_FFFF;
        s.cost = total[31:0];
        if ((total >>> 16) >= 12) begin
            s.lik = '0;
        end else begin
            k   = int'(total >>> 16);
            acc = exp_series(total & 64'hFFFF);
            e1  = exp_series(65536);
            repeat (k) acc = (acc * e1 + (64'h1 << 30)) >> 31;
            lik = (acc + (64'h1 << 14)) >> 15;
            s.lik = (lik > 65535) ? 16'hFFFF : lik[15:0];
        end
        return s;
    endfunction

    // ------------------------------------------------------------------
    // Result check: receiver never stalls, so every strobe is a transfer
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_score want;
        if (i_rst_n && o_strobe) begin
            if (pending_scores.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= REPORT_MAX)
                    $display("unexpected result: lik=%0d cost=%0d zero=%0d",
                             o_likelihood, o_cost_value, o_zero_force_flag);
            end else begin
                want = pending_scores.pop_front();
                if (o_likelihood !== want.lik || o_cost_value !== want.cost
                    || o_zero_force_flag !== want.zero) begin
                    mismatch_count++;
                    if (mismatch_count <= REPORT_MAX)
                        $display({"mismatch: exp lik=%0d cost=%0d zero=%0d,",
                                  " got lik=%0d cost=%0d zero=%0d"},
                                 want.lik, want.cost, want.zero,
                                 o_likelihood, o_cost_value, o_zero_force_flag);
                end
            end
        end
    end

    // Watchdog: end the run after a long stretch with no transfer anywhere
    always @(posedge i_clk) begin
        if ((start && !busy) || o_strobe || (i_cfg_valid && o_cfg_ready) || !i_rst_n) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("contact_point_likelihood_top test failed");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    // Send one candidate after a random gap; start stays high for back-to-back items
    task automatic send_contact(t_contact c);
        int gap;
        gap = $urandom_range(0, 3);
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start          <= 1'b1;
        i_point_x      <= c.px;
        i_point_y      <= c.py;
        i_point_z      <= c.pz;
        i_normal_x     <= c.nx;
        i_normal_y     <= c.ny;
        i_normal_z     <= c.nz;
        i_cand_force_x <= c.fx;
        i_cand_force_y <= c.fy;
        i_cand_force_z <= c.fz;
        do @(posedge i_clk); while (busy);
        pending_scores.insert(pending_scores.size(), score_contact(c));
    endtask

    // Hold until the pipeline has drained
    task automatic drain_pipeline();
        start <= 1'b0;
        @(posedge i_clk);
        while (pending_scores.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 4) @(posedge i_clk);
    endtask

    task automatic write_register(logic [2:0] idx, logic [31:0] data);
        drain_pipeline();
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        case (idx)
            REG_MF_X: wrench_force[0]  = data;
            REG_MF_Y: wrench_force[1]  = data;
            REG_MF_Z: wrench_force[2]  = data;
            REG_MT_X: wrench_torque[0] = data;
            REG_MT_Y: wrench_torque[1] = data;
            REG_MT_Z: wrench_torque[2] = data;
            REG_AXIS: axis_mask        = data[2:0];
            default: ;
        endcase
    endtask

    task automatic write_wrench(logic [31:0] f[3], logic [31:0] t[3]);
        write_register(REG_MF_X, f[0]);
        write_register(REG_MF_Y, f[1]);
        write_register(REG_MF_Z, f[2]);
        write_register(REG_MT_X, t[0]);
        write_register(REG_MT_Y, t[1]);
        write_register(REG_MT_Z, t[2]);
    endtask

    function automatic logic [31:0] any_s32();
        case ($urandom_range(0, 3))
            0: return $urandom;
            1: return $urandom_range(0, 262143) - 131072;
            2: case ($urandom_range(0, 3))
                   0: return 32'h8000_0000;
                   1: return 32'h7FFF_FFFF;
                   2: return 32'h0;
                   default: return 32'hFFFF_FFFF;
               endcase
            default: return $urandom_range(0, 2047) - 1024;
        endcase
    endfunction

    function automatic logic [15:0] any_s16();
        logic [31:0] r;
        r = $urandom;
        return ($urandom_range(0, 3) == 0) ? 16'h8000 : r[15:0];
    endfunction

    function automatic t_contact noise_contact();
        t_contact c;
        c.px = any_s32(); c.py = any_s32(); c.pz = any_s32();
        c.nx = any_s16(); c.ny = any_s16(); c.nz = any_s16();
        c.fx = any_s32(); c.fy = any_s32(); c.fz = any_s32();
        return c;
    endfunction

    // Near-unit normal: one dominant axis of either sign plus small tilt
    function automatic void unit_normal(ref t_contact c);
        logic signed [15:0] n[3];
        int                 ax;
        for (int i = 0; i < 3; i++) n[i] = 16'($urandom_range(0, 2047) - 1024);
        ax    = $urandom_range(0, 2);
        n[ax] = $urandom_range(0, 1) ? 16'sd16384 : -16'sd16384;
        c.nx = n[0]; c.ny = n[1]; c.nz = n[2];
    endfunction

    // Candidate close to a plausible contact (p0, f0), so the cost stays low
    function automatic t_contact near_contact(longint p0[3], longint f0[3]);
        t_contact c;
        c.px = 32'(p0[0] + $urandom_range(0, 8191) - 4096);
        c.py = 32'(p0[1] + $urandom_range(0, 8191) - 4096);
        c.pz = 32'(p0[2] + $urandom_range(0, 8191) - 4096);
        c.fx = 32'(f0[0] + $urandom_range(0, 65535) - 32768);
        c.fy = 32'(f0[1] + $urandom_range(0, 65535) - 32768);
        c.fz = 32'(f0[2] + $urandom_range(0, 65535) - 32768);
        unit_normal(c);
        return c;
    endfunction

    // Load a measured wrench that matches a random contact, and return it
    task automatic load_matching_wrench(output longint p0[3], output longint f0[3]);
        longint      t0[3];
        logic [31:0] fw[3], tw[3];
        for (int i = 0; i < 3; i++) begin
            p0[i] = longint'($urandom_range(0, 262143)) - 131072;
            f0[i] = longint'($urandom_range(0, 4194303)) - 2097152;
        end
        cross_torque(p0, f0, t0);
        for (int i = 0; i < 3; i++) begin
            fw[i] = f0[i][31:0];
            tw[i] = t0[i][31:0];
        end
        write_wrench(fw, tw);
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------
    // Reset wrench is zero: flag set, alignment at one half
    task automatic test_reset_wrench();
        repeat (4) send_contact(noise_contact());
    endtask

    task automatic test_directed_cases();
        t_contact    c;
        logic [31:0] fw[3], tw[3];
        fw = '{32'h0001_0000, 32'h0, 32'h0};
        tw = '{32'h0, 32'h0, 32'h0};
        write_wrench(fw, tw);
        write_register(REG_AXIS, 32'hFFFF_FFFF);
        // Exact match and normal opposing at magnitude two: negative cost clamps to zero
        c = '{px: 0, py: 0, pz: 0, nx: -16'sd32768, ny: 0, nz: 0,
              fx: 32'sh0001_0000, fy: 0, fz: 0};
        send_contact(c);
        // Exact match, normal along the force: cost one
        c.nx = 16'sd16384;
        send_contact(c);
        c.nx = 16'sd32767;
        send_contact(c);
        // All-zero candidate
        c = '{default: 0};
        send_contact(c);
        // Field extremes: clamped residuals, saturated cost
        c = '{px: 32'sh7FFF_FFFF, py: 32'sh8000_0000, pz: 32'sh7FFF_FFFF,
              nx: 16'sh7FFF, ny: 16'sh8000, nz: 16'sh7FFF,
              fx: 32'sh8000_0000, fy: 32'sh7FFF_FFFF, fz: 32'sh8000_0000};
        send_contact(c);
        c = '{px: 32'sh8000_0000, py: 32'sh8000_0000, pz: 32'sh8000_0000,
              nx: 16'sh8000, ny: 16'sh8000, nz: 16'sh8000,
              fx: 32'sh8000_0000, fy: 32'sh8000_0000, fz: 32'sh8000_0000};
        send_contact(c);
        c = '{px: -1, py: -1, pz: -1, nx: -1, ny: -1, nz: -1, fx: -1, fy: -1, fz: -1};
        send_contact(c);
        // Cost just under and at the zero-likelihood bound
        c = '{px: 0, py: 0, pz: 0, nx: 16'sd16384, ny: 0, nz: 0,
              fx: 32'sh0001_0000 - 32'sd2818048, fy: 0, fz: 0};
        send_contact(c);
        c.fx = 32'sh0001_0000 - 32'sd2883584;
        send_contact(c);
        // Extreme wrench registers
        fw = '{32'h8000_0000, 32'h8000_0000, 32'h8000_0000};
        tw = '{32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF};
        write_wrench(fw, tw);
        repeat (4) send_contact(noise_contact());
        fw = '{32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF};
        tw = '{32'h8000_0000, 32'h8000_0000, 32'h8000_0000};
        write_wrench(fw, tw);
        repeat (4) send_contact(noise_contact());
        // Write to the unused index must leave every register alone
        write_register(REG_UNUSED, 32'h0);
        repeat (4) send_contact(noise_contact());
    endtask

    // Every axis mask, against a wrench that matches the nominal contact
    task automatic test_axis_masks();
        longint p0[3], f0[3];
        for (int m = 0; m < 8; m++) begin
            load_matching_wrench(p0, f0);
            write_register(REG_AXIS, {$urandom} & ~32'h7 | m);
            repeat (30) send_contact(near_contact(p0, f0));
            repeat (5) send_contact(noise_contact());
        end
    endtask

    // Mostly well-matched candidates per phase, with noise mixed in
    task automatic test_random_stream();
        longint p0[3], f0[3];
        for (int phase = 0; phase < 11; phase++) begin
            load_matching_wrench(p0, f0);
            write_register(REG_AXIS, (phase % 3 == 0) ? 32'h7 : $urandom_range(0, 7));
            for (int i = 0; i < 100; i++) begin
                if ($urandom_range(0, 4) == 0) send_contact(noise_contact());
                else                           send_contact(near_contact(p0, f0));
                if (phase == 4 && i == 50) drain_pipeline();
            end
        end
    endtask

    initial begin
        i_rst_n        <= 1'b0;
        start          <= 1'b0;
        i_point_x      <= '0;
        i_point_y      <= '0;
        i_point_z      <= '0;
        i_normal_x     <= '0;
        i_normal_y     <= '0;
        i_normal_z     <= '0;
        i_cand_force_x <= '0;
        i_cand_force_y <= '0;
        i_cand_force_z <= '0;
        i_cfg_valid    <= 1'b0;
        i_cfg_index    <= '0;
        i_cfg_data     <= '0;
        wrench_force   = '{0, 0, 0};
        wrench_torque  = '{0, 0, 0};
        axis_mask      = 3'h7;
        mismatch_count = 0;
        idle_cycles    = 0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_wrench();
        test_directed_cases();
        test_axis_masks();
        test_random_stream();

        // Let the last results out, then allow a short tail for stray strobes
        drain_pipeline();
        if (mismatch_count == 0 && pending_scores.size() == 0) begin
            $display("contact_point_likelihood_top test passed");
        end else begin
            $display("contact_point_likelihood_top test failed");
        end
        $finish;
    end

endmodule
